/* hw/rtl/grr_pkg.sv */
// grr_pkg: shared types, register codes and helpers for the gradient ramp.
// Used by every module under hw/rtl; depends on nothing else.
package grr_pkg;

  localparam int NUM_STOP_REGS = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int STOP_W        = 24;
  localparam int POS_W         = 8;
  localparam int COLOR_W       = 16;
  localparam int LEVEL_W       = 8;
  localparam int DIV_STEPS     = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_0     = 3'd1;

  localparam logic [STOP_W-1:0] STOP_RESET [NUM_STOP_REGS] = '{
    24'h000947, 24'h193BA2, 24'h3C9CC0, 24'h63F800
  };

  // alpha division in flight: quotient bits are shifted in msb first
  typedef struct packed {
    logic                 full;
    logic [POS_W-1:0]     rem;
    logic [POS_W-1:0]     num_lo;
    logic [POS_W-1:0]     quot;
    logic [POS_W-1:0]     denom;
    logic [COLOR_W-1:0]   color_a;
    logic [COLOR_W-1:0]   color_b;
  } div_t;

  // exact x / 255 for x up to 63 * 255
  function automatic logic [5:0] div255(input logic [13:0] x);
    logic [14:0] s;
    s = {1'b0, x} + 15'd1 + 15'(x[13:8]);
    return s[13:8];
  endfunction

endpackage

/* hw/rtl/grr_cfg_regs.sv */
// grr_cfg_regs: stop count and stop registers, written through the config port.
// Depends on grr_pkg.
module grr_cfg_regs #(
  parameter int NUM_STOPS = 4,
  parameter int CNT_W     = $clog2(NUM_STOPS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [grr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [grr_pkg::STOP_W-1:0]          cfg_data_i,
  output logic [CNT_W-1:0]                    count_o,
  output logic [grr_pkg::STOP_W-1:0]          stops_o [NUM_STOPS]
);

  logic [CNT_W-1:0]           count_q;
  logic [CNT_W-1:0]           count_d;
  logic [grr_pkg::STOP_W-1:0] stops_q [NUM_STOPS];
  logic                       we;
  logic [2:0]                 raw;

  assign cfg_ready_o = 1'b1;
  assign we          = cfg_valid_i && cfg_ready_o;
  assign raw         = cfg_data_i[2:0];

  // count is kept already clamped to 1..NUM_STOPS
  always_comb begin
    if (raw == 3'd0) begin
      count_d = CNT_W'(1);
    end else if (raw > 3'(NUM_STOPS)) begin
      count_d = CNT_W'(NUM_STOPS);
    end else begin
      count_d = CNT_W'(raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(NUM_STOPS);
      for (int i = 0; i < NUM_STOPS; i++) begin
        stops_q[i] <= grr_pkg::STOP_RESET[i];
      end
    end else if (we) begin
      if (cfg_index_i == grr_pkg::REG_STOP_COUNT) begin
        count_q <= count_d;
      end
      for (int i = 0; i < NUM_STOPS; i++) begin
        if (cfg_index_i == grr_pkg::CFG_IDX_W'(grr_pkg::REG_STOP_0 + i)) begin
          stops_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign count_o = count_q;
  assign stops_o = stops_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(NUM_STOPS)))
    else $error("stop count out of range");

endmodule

/* hw/rtl/grr_seg_sel.sv */
// grr_seg_sel: first pipeline stage, clamps the level and picks the segment,
// then forms the alpha numerator. Depends on grr_pkg.
module grr_seg_sel #(
  parameter int NUM_STOPS = 4,
  parameter int CNT_W     = $clog2(NUM_STOPS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic [grr_pkg::STOP_W-1:0]        stops_i [NUM_STOPS],
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [grr_pkg::LEVEL_W-1:0]       level_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output grr_pkg::div_t                     out_o
);

  logic                  vld_q;
  grr_pkg::div_t         data_q;
  grr_pkg::div_t         data_d;
  logic                  full;
  logic                  found;
  logic [7:0]            lo;
  logic [7:0]            hi;
  logic [7:0]            diff;
  logic [7:0]            denom;
  logic [15:0]           ca;
  logic [15:0]           cb;
  logic [15:0]           num;
  logic [23:0]           last;

  always_comb begin
    full  = 1'b1;
    found = 1'b0;
    lo    = '0;
    hi    = '0;
    diff  = '0;
    denom = '0;
    ca    = stops_i[0][15:0];
    cb    = stops_i[0][15:0];
    last  = stops_i[0];
    for (int i = 0; i < NUM_STOPS; i++) begin
      if (CNT_W'(i + 1) == count_i) begin
        last = stops_i[i];
      end
    end
    // walk down so the lowest matching segment wins
    for (int i = NUM_STOPS - 2; i >= 0; i--) begin
      if ((CNT_W'(i + 2) <= count_i) && (level_i <= stops_i[i+1][23:16])) begin
        found = 1'b1;
        lo    = stops_i[i][23:16];
        hi    = stops_i[i+1][23:16];
        ca    = stops_i[i][15:0];
        cb    = stops_i[i+1][15:0];
      end
    end
    if (level_i <= stops_i[0][23:16]) begin
      cb = stops_i[0][15:0];
    end else if (level_i >= last[23:16]) begin
      cb = last[15:0];
    end else if (!found) begin
      cb = last[15:0];
    end else if (hi > lo) begin
      full  = 1'b0;
      denom = hi - lo;
      diff  = (level_i > lo) ? (level_i - lo) : 8'd0;
    end
    // diff * 255
    num = {diff, 8'h00} - {8'h00, diff};

    data_d.full    = full;
    data_d.rem     = num[15:8];
    data_d.num_lo  = num[7:0];
    data_d.quot    = '0;
    data_d.denom   = denom;
    data_d.color_a = ca;
    data_d.color_b = cb;
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !data_q.full) |-> (data_q.denom != '0) && (data_q.rem < data_q.denom))
    else $error("alpha division starts out of range");

endmodule

/* hw/rtl/grr_div_stage.sv */
// grr_div_stage: one pipeline stage of the restoring alpha divider,
// DIV_STEPS quotient bits per stage. Depends on grr_pkg.
module grr_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  grr_pkg::div_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output grr_pkg::div_t    out_o
);

  logic             vld_q;
  grr_pkg::div_t    data_q;
  grr_pkg::div_t    data_d;
  logic [8:0]       t;
  logic             qbit;

  always_comb begin
    data_d = in_i;
    t      = '0;
    qbit   = 1'b0;
    for (int k = 0; k < grr_pkg::DIV_STEPS; k++) begin
      t = {data_d.rem, data_d.num_lo[7]};
      if (t >= {1'b0, data_d.denom}) begin
        data_d.rem = 8'(t - {1'b0, data_d.denom});
        qbit       = 1'b1;
      end else begin
        data_d.rem = t[7:0];
        qbit       = 1'b0;
      end
      data_d.num_lo = {data_d.num_lo[6:0], 1'b0};
      data_d.quot   = {data_d.quot[6:0], qbit};
    end
  end

  assign in_ready_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = data_q;

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !data_q.full) |-> (data_q.rem < data_q.denom))
    else $error("divider remainder not below divisor");

endmodule

/* hw/rtl/grr_blend.sv */
// grr_blend: two pipeline stages that mix the 5/6/5 channels by alpha and
// divide by 255; the second stage is the output register. Depends on grr_pkg.
module grr_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  grr_pkg::div_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [grr_pkg::COLOR_W-1:0]   color_o
);

  typedef struct packed {
    logic [13:0] r;
    logic [13:0] g;
    logic [13:0] b;
  } mix_t;

  logic          vld_a_q;
  logic          vld_b_q;
  logic          rdy_b;
  mix_t          mix_q;
  mix_t          mix_d;
  logic [15:0]   color_q;
  logic [15:0]   color_d;
  logic [7:0]    alpha;
  logic [7:0]    inv;

  // a clamped item takes color_b whole
  assign alpha = in_i.full ? 8'hFF : in_i.quot;
  assign inv   = 8'hFF - alpha;

  always_comb begin
    mix_d.r = 14'(in_i.color_a[15:11]) * 14'(inv) + 14'(in_i.color_b[15:11]) * 14'(alpha);
    mix_d.g = 14'(in_i.color_a[10:5]) * 14'(inv) + 14'(in_i.color_b[10:5]) * 14'(alpha);
    mix_d.b = 14'(in_i.color_a[4:0]) * 14'(inv) + 14'(in_i.color_b[4:0]) * 14'(alpha);
  end

  always_comb begin
    logic [5:0] r6;
    logic [5:0] g6;
    logic [5:0] b6;
    r6 = grr_pkg::div255(mix_q.r);
    g6 = grr_pkg::div255(mix_q.g);
    b6 = grr_pkg::div255(mix_q.b);
    color_d = {r6[4:0], g6, b6[4:0]};
  end

  assign rdy_b      = !vld_b_q || out_ready_i;
  assign in_ready_o = !vld_a_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        vld_a_q <= in_valid_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mix_q <= mix_d;
    end
    if (vld_a_q && rdy_b) begin
      color_q <= color_d;
    end
  end

  assign out_valid_o = vld_b_q;
  assign color_o     = color_q;

  a_mix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q |-> (mix_q.r <= 14'd7905) && (mix_q.g <= 14'd16065) && (mix_q.b <= 14'd7905))
    else $error("channel mix exceeds full scale");

endmodule

/* hw/rtl/gradient_ramp_rgb565.sv */
// gradient_ramp_rgb565: level to RGB565 through a piecewise-linear gradient.
// Instantiates grr_cfg_regs, grr_seg_sel, grr_div_stage, grr_blend; uses grr_pkg.
//
//   channel   handshake                  payload
//   input     in_valid_i / in_ready_o    level_i [7:0]
//   output    out_valid_o / out_ready_i  color_o [15:0]
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i [2:0], cfg_data_i [23:0]
//
// one item per cycle sustained while the output is not stalled; the stages in order: segment
// select, two divider stages of 4 quotient bits each, channel mix, divide by 255 into the
// output register. every stage has its own valid bit and a stage moves when
// the one after it is empty or moving, so a stalled output backs up without
// loss. reset loads the documented stop values; config is always ready.
module gradient_ramp_rgb565 #(
  parameter int MAX_STOPS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [grr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [grr_pkg::STOP_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [grr_pkg::LEVEL_W-1:0]         level_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [grr_pkg::COLOR_W-1:0]         color_o
);

  localparam int NumStops = (MAX_STOPS < grr_pkg::NUM_STOP_REGS) ?
                            MAX_STOPS : grr_pkg::NUM_STOP_REGS;
  localparam int CntW     = $clog2(NumStops + 1);

  logic [CntW-1:0]            count;
  logic [grr_pkg::STOP_W-1:0] stops [NumStops];
  logic                       s1_valid;
  logic                       s1_ready;
  grr_pkg::div_t              s1_data;
  logic                       s2_valid;
  logic                       s2_ready;
  grr_pkg::div_t              s2_data;
  logic                       s3_valid;
  logic                       s3_ready;
  grr_pkg::div_t              s3_data;

  grr_cfg_regs #(
    .NUM_STOPS (NumStops),
    .CNT_W     (CntW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .count_o     (count),
    .stops_o     (stops)
  );

  grr_seg_sel #(
    .NUM_STOPS (NumStops),
    .CNT_W     (CntW)
  ) u_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count),
    .stops_i     (stops),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .level_i     (level_i),
    .out_valid_o (s1_valid),
    .out_ready_i (s1_ready),
    .out_o       (s1_data)
  );

  grr_div_stage u_div_hi (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .in_i        (s1_data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_o       (s2_data)
  );

  grr_div_stage u_div_lo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_i        (s2_data),
    .out_valid_o (s3_valid),
    .out_ready_i (s3_ready),
    .out_o       (s3_data)
  );

  grr_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_valid),
    .in_ready_o  (s3_ready),
    .in_i        (s3_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .color_o     (color_o)
  );

  // a moving output frees the whole chain
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output is free");

endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for gradient_ramp_rgb565, level in, RGB565 color out
// keeps its own copy of the stop registers and predicts every color from it
// depends on grr_pkg and the rtl under hw/rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STOPS      = 4;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int PIPE_LATENCY   = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int RANDOM_PHASES  = 11;
  localparam int PHASE_LEVELS   = 55;

  localparam int NSTOPS = grr_pkg::NUM_STOP_REGS;
  localparam logic [grr_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
    grr_pkg::REG_STOP_0 + grr_pkg::CFG_IDX_W'(NSTOPS);
  localparam logic [grr_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

  typedef enum int {RX_FULL, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [grr_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [grr_pkg::STOP_W-1:0]     cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [grr_pkg::LEVEL_W-1:0]    level_i     = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [grr_pkg::COLOR_W-1:0]    color_o;

  // shadow of the stop registers
  logic [2:0]                     cur_stop_count = 3'd4;
  logic [grr_pkg::STOP_W-1:0]     cur_stops [NSTOPS] = grr_pkg::STOP_RESET;

  logic [grr_pkg::COLOR_W-1:0]    pending_colors [$];
  int                             color_errors = 0;
  int                             burst_left   = 0;
  int                             holdoff_req  = 0;

  gradient_ramp_rgb565 #(
    .MAX_STOPS(MAX_STOPS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .level_i(level_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .color_o(color_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [15:0] gradient_color(input logic [7:0] lvl);
    int n, i, l, lo, hi, alpha, r, g, b;
    logic [15:0] ca, cb;
    n = int'(cur_stop_count);
    l = int'(lvl);
    if (n < 1) n = 1;
    if (n > MAX_STOPS) n = MAX_STOPS;
    if (n > NSTOPS) n = NSTOPS;
    if (l <= int'(cur_stops[0][23:16])) return cur_stops[0][15:0];
    if (l >= int'(cur_stops[n-1][23:16])) return cur_stops[n-1][15:0];
    for (i = 0; i + 1 < n; i++) begin
      lo = int'(cur_stops[i][23:16]);
      hi = int'(cur_stops[i+1][23:16]);
      if (l <= hi) begin
        if (hi <= lo) return cur_stops[i+1][15:0];
        alpha = (l > lo) ? ((l - lo) * 255) / (hi - lo) : 0;
        ca = cur_stops[i][15:0];
        cb = cur_stops[i+1][15:0];
        r = (int'(ca[15:11]) * (255 - alpha) + int'(cb[15:11]) * alpha) / 255;
        g = (int'(ca[10:5]) * (255 - alpha) + int'(cb[10:5]) * alpha) / 255;
        b = (int'(ca[4:0]) * (255 - alpha) + int'(cb[4:0]) * alpha) / 255;
        return {5'(r), 6'(g), 5'(b)};
      end
    end
    return cur_stops[n-1][15:0];
  endfunction

  // sender in bursts, random gaps between them
  task automatic send_level(input logic [7:0] lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    level_i    <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    pending_colors.push_back(gradient_color(lvl));
    burst_left--;
  endtask

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high so back-to-back writes need one assignment per edge
  task automatic write_reg(input logic [grr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [grr_pkg::STOP_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == grr_pkg::REG_STOP_COUNT) cur_stop_count = data[2:0];
    else if (idx >= grr_pkg::REG_STOP_0 && idx < REG_SPARE_FIRST)
      cur_stops[2'(idx - grr_pkg::REG_STOP_0)] = data;
  endtask

  task automatic program_gradient(input logic [2:0] cnt, input logic [23:0] s0,
                                  input logic [23:0] s1, input logic [23:0] s2,
                                  input logic [23:0] s3);
    settle_pipeline();
    // upper data bits of the count write are don't-care
    write_reg(grr_pkg::REG_STOP_COUNT, {21'($urandom), cnt});
    write_reg(grr_pkg::REG_STOP_0, s0);
    write_reg(grr_pkg::CFG_IDX_W'(grr_pkg::REG_STOP_0 + 1), s1);
    write_reg(grr_pkg::CFG_IDX_W'(grr_pkg::REG_STOP_0 + 2), s2);
    write_reg(grr_pkg::CFG_IDX_W'(grr_pkg::REG_STOP_0 + 3), s3);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_random_gradient();
    logic [2:0]  cnt;
    logic [23:0] w [NSTOPS];
    int p, k, v;
    if ($urandom_range(0, 5) == 0) begin
      v = $urandom_range(4, 7);
      cnt = (v == 4) ? 3'd0 : 3'(v);
    end else begin
      cnt = 3'($urandom_range(1, 4));
    end
    p = $urandom_range(0, 96);
    for (k = 0; k < NSTOPS; k++) begin
      w[k] = {8'(p), 16'($urandom)};
      p += $urandom_range(0, 96);
      if (p > 255) p = 255;
    end
    // occasionally unsorted positions
    if ($urandom_range(0, 7) == 0) begin
      for (k = 0; k < NSTOPS; k++) w[k][23:16] = 8'($urandom);
    end
    program_gradient(cnt, w[0], w[1], w[2], w[3]);
  endtask

  task automatic test_reset_gradient();
    logic [7:0] levels [10] = '{8'h00, 8'h01, 8'h18, 8'h19, 8'h1A,
                                8'h3B, 8'h3C, 8'h62, 8'h63, 8'hFF};
    foreach (levels[k]) send_level(levels[k]);
  endtask

  task automatic test_special_stops();
    // full-range black to white
    program_gradient(3'd2, 24'h000000, 24'hFFFFFF, 24'hFF0000, 24'hFF0000);
    send_level(8'h00);
    send_level(8'h01);
    send_level(8'h80);
    send_level(8'hFF);
    // zero count falls back to one stop
    program_gradient(3'd0, 24'h40ABCD, 24'h801234, 24'hC05678, 24'hF09ABC);
    send_level(8'h10);
    send_level(8'hC0);
    // single stop
    program_gradient(3'd1, 24'h7F5555, 24'h80AAAA, 24'hC00F0F, 24'hFFF0F0);
    send_level(8'hE1);
    // spare indexes must not disturb the stops
    settle_pipeline();
    write_reg(REG_SPARE_FIRST, 24'($urandom));
    write_reg(REG_SPARE_LAST, 24'($urandom));
    cfg_valid_i <= 1'b0;
    // oversized count saturates to four stops
    program_gradient(3'd7, 24'h10F800, 24'h2007E0, 24'h30001F, 24'hF0FFFF);
    send_level(8'hF0);
    send_level(8'h90);
    // all positions equal
    program_gradient(3'd4, 24'h501111, 24'h502222, 24'h503333, 24'h504444);
    send_level(8'h4F);
    send_level(8'h50);
    send_level(8'h51);
    // unsorted stops
    program_gradient(3'd4, 24'h20F81F, 24'hA007FF, 24'h30FFE0, 24'hE00000);
    send_level(8'h50);
    send_level(8'hB0);
  endtask

  task automatic test_backpressure();
    apply_random_gradient();
    holdoff_req = HOLDOFF_CYCLES;
    burst_left = 1000;
    repeat (40) send_level(8'($urandom));
    // sender waits for every color before going on
    settle_pipeline();
    burst_left = 1000;
    repeat (20) send_level(8'($urandom));
    settle_pipeline();
  endtask

  task automatic test_random_gradients();
    logic [7:0] lvl;
    int p;
    repeat (RANDOM_PHASES) begin
      apply_random_gradient();
      repeat (PHASE_LEVELS) begin
        if ($urandom_range(0, 3) == 0) begin
          // land close to a stop position
          p = int'(cur_stops[2'($urandom_range(0, NSTOPS - 1))][23:16]) +
              $urandom_range(0, 4) - 2;
          if (p < 0) p = 0;
          if (p > 255) p = 255;
          lvl = 8'(p);
        end else begin
          lvl = 8'($urandom_range(0, 255));
        end
        send_level(lvl);
      end
    end
  endtask

  // receiver stalls on its own pattern, plus long hold-offs on request
  initial begin : receiver
    rx_mode_e mode;
    int mode_left, hold_left;
    mode = RX_FULL;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req != 0) begin
        hold_left = holdoff_req;
        holdoff_req = 0;
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          RX_FULL:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:   out_ready_i <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_colors.size() == 0) begin
        $error("color: expected none, actual %h", color_o);
        color_errors++;
      end else if (color_o !== pending_colors[0]) begin
        $error("color: expected %h, actual %h", pending_colors[0], color_o);
        color_errors++;
        void'(pending_colors.pop_front());
      end else begin
        void'(pending_colors.pop_front());
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("gradient_ramp_rgb565 test failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_gradient();
    test_special_stops();
    test_backpressure();
    test_random_gradients();
    settle_pipeline();
    if (color_errors == 0 && pending_colors.size() == 0) begin
      $display("gradient_ramp_rgb565 test passed");
    end else begin
      $display("gradient_ramp_rgb565 test failed");
    end
    $finish;
  end

endmodule
